FILE: rtl/thermistor_adc_to_celsius_unit_macros.svh
// Assertion macros shared by the thermistor conversion block.
`ifndef THERMISTOR_ADC_TO_CELSIUS_UNIT_MACROS_SVH
`define THERMISTOR_ADC_TO_CELSIUS_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked at every rising clock edge outside of reset.
`define TACU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be seen outside of reset.
`define TACU_ASSERT_NEVER(label, cond, msg) `TACU_ASSERT(label, !(cond), msg)
`else
`define TACU_ASSERT(label, prop, msg)
`define TACU_ASSERT_NEVER(label, cond, msg)
`endif
`endif

FILE: rtl/tacu_pkg.sv
`default_nettype none
package tacu_pkg;

    // Field and register widths.
    localparam int CODE_W  = 12;
    localparam int TEMP_W  = 17;
    localparam int COEF_W  = 48;
    localparam int DIV_W   = 20;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;
    localparam int REG_LSB = 3;

    // Log2 datapath: input width, Q28 result, normalized Q30 mantissa.
    localparam int LX_W      = 20;
    localparam int LG_FRAC   = 28;
    localparam int LG_EXP_W  = 5;
    localparam int LG_W      = LG_EXP_W + LG_FRAC;
    localparam int MANT_W    = 31;
    localparam int LOG_LAT   = LG_FRAC + 1;

    // Signed widths of the Steinhart-Hart terms.
    localparam int G_W   = 36;
    localparam int LN2_W = 31;
    localparam int L_W   = 35;
    localparam int L2_W  = 40;
    localparam int L3_W  = 45;
    localparam int TB_W  = 54;
    localparam int TC_W  = 63;
    localparam int S_W   = 64;

    // Multiplier split and latency.
    localparam int MUL_SPLIT = 24;
    localparam int MUL_LAT   = 5;

    // Reciprocal: 2^64 / d with d >= 2^46 gives at most 19 quotient bits.
    localparam int D_W      = 62;
    localparam int REM_W    = 63;
    localparam int Q_W      = 19;
    localparam int K_W      = Q_W + 1;
    localparam int TINY_EXP = 46;
    localparam int DIV_LAT  = Q_W + 2;
    localparam logic [REM_W-1:0] REM_INIT = REM_W'(1) << (64 - Q_W);

    // Constants.
    localparam logic [LN2_W-1:0] LN2_Q30   = 31'd744261118;
    localparam int               KELVIN_Q8 = 69926;
    localparam int               TEMP_MAX  = 65535;
    localparam int               TEMP_MIN  = -65536;

    // Defaults.
    localparam int unsigned      ADC_FULL_SCALE_DEF = 4095;
    localparam logic [COEF_W-1:0] COEF_A_RST  = 48'd72724093000000;
    localparam logic [COEF_W-1:0] COEF_B_RST  = 48'd17138340000000;
    localparam logic [COEF_W-1:0] COEF_C_RST  = 48'd14549891000;
    localparam logic [DIV_W-1:0]  DIVIDER_RST = 20'd10000;

    // Register map, by index.
    typedef enum logic [1:0] {
        REG_COEF_A  = 2'd0,
        REG_COEF_B  = 2'd1,
        REG_COEF_C  = 2'd2,
        REG_DIVIDER = 2'd3
    } tacu_reg_t;

    // Control that travels with each item down the pipeline.
    typedef struct packed {
        logic valid;
        logic in_range;
    } tacu_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/tacu_log2.sv
`default_nettype none
module tacu_log2 (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic [tacu_pkg::LX_W-1:0] x,
    output logic      [tacu_pkg::LG_W-1:0] lg
);
    import tacu_pkg::*;

    logic [LG_EXP_W-1:0] exp_next;
    logic [MANT_W-1:0]   mant_next;
    logic [LG_EXP_W-1:0] exp_reg  [0:LG_FRAC];
    logic [MANT_W-1:0]   mant_reg [0:LG_FRAC];
    logic [LG_FRAC-1:0]  frac_reg [0:LG_FRAC];

    // Find the top set bit and normalize the mantissa to Q30.
    always_comb
    begin
        exp_next = '0;
        for (int i = 1; i < LX_W; i++)
        begin
            if (x[i])
            begin
                exp_next = LG_EXP_W'(i);
            end
        end
        mant_next = MANT_W'(MANT_W'(x) << (LG_EXP_W'(MANT_W - 1) - exp_next));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            exp_reg[0]  <= exp_next;
            mant_reg[0] <= mant_next;
            frac_reg[0] <= '0;
        end
    end

    // One squaring round per stage yields one fraction bit.
    for (genvar r = 0; r < LG_FRAC; r++)
    begin : g_round
        logic [2*MANT_W-1:0] sq;
        logic [MANT_W:0]     sqs;

        assign sq  = mant_reg[r] * mant_reg[r];
        assign sqs = sq[2*MANT_W-1 -: MANT_W+1];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                exp_reg[r+1]  <= exp_reg[r];
                mant_reg[r+1] <= sqs[MANT_W] ? sqs[MANT_W:1] : sqs[MANT_W-1:0];
                frac_reg[r+1] <= frac_reg[r]
                               | (sqs[MANT_W] ? (LG_FRAC'(1) << (LG_FRAC - 1 - r)) : '0);
            end
        end
    end

    assign lg = {exp_reg[LG_FRAC], frac_reg[LG_FRAC]};

endmodule
`default_nettype wire

FILE: rtl/tacu_mulsh.sv
`default_nettype none
module tacu_mulsh #(
    parameter int WA = 48,
    parameter int WB = 48,
    parameter int SH = 28,
    parameter int WO = 64
) (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic signed [WA-1:0] a,
    input  wire logic signed [WB-1:0] b,
    output logic      signed [WO-1:0] p
);
    import tacu_pkg::*;

    localparam int H  = MUL_SPLIT;
    localparam int PW = WA + WB + 1;

    logic              neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    logic [WA-1:0]     ma_reg;
    logic [WB-1:0]     mb_reg;
    logic [2*H-1:0]    p00_reg;
    logic [WB-1:0]     p01_reg;
    logic [WA-1:0]     p10_reg;
    logic [WA+WB-2*H-1:0] p11_reg;
    logic [PW-1:0]     low_reg, mid_reg, hi_reg;
    logic [PW-1:0]     tot;
    logic [WO-2:0]     mag_reg;
    logic signed [WO-1:0] p_reg;

    // Total of the partial products, rounding term already in low_reg.
    assign tot = low_reg + (mid_reg << H) + (hi_reg << (2 * H));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Magnitudes and sign of the result.
            neg1_reg <= a[WA-1] ^ b[WB-1];
            ma_reg   <= a[WA-1] ? WA'(-a) : WA'(a);
            mb_reg   <= b[WB-1] ? WB'(-b) : WB'(b);
            // Partial products.
            neg2_reg <= neg1_reg;
            p00_reg  <= ma_reg[H-1:0] * mb_reg[H-1:0];
            p01_reg  <= ma_reg[H-1:0] * mb_reg[WB-1:H];
            p10_reg  <= ma_reg[WA-1:H] * mb_reg[H-1:0];
            p11_reg  <= ma_reg[WA-1:H] * mb_reg[WB-1:H];
            // Low part with the half-unit rounding, and the middle sum.
            neg3_reg <= neg2_reg;
            low_reg  <= PW'(p00_reg) + (PW'(1) << (SH - 1));
            mid_reg  <= PW'(p01_reg) + PW'(p10_reg);
            hi_reg   <= PW'(p11_reg);
            // Rounded and shifted magnitude.
            neg4_reg <= neg3_reg;
            mag_reg  <= tot[SH +: WO-1];
            // Sign applied.
            p_reg    <= neg4_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
        end
    end

    assign p = p_reg;

endmodule
`default_nettype wire

FILE: rtl/tacu_recip.sv
`default_nettype none
module tacu_recip (
    input  wire logic                               clk,
    input  wire logic                               en,
    input  wire logic        [tacu_pkg::D_W-1:0]    d,
    input  wire logic                               neg,
    input  wire logic                               tiny,
    output logic      signed [tacu_pkg::TEMP_W-1:0] temp
);
    import tacu_pkg::*;

    localparam int T_W = K_W + 2;

    logic [REM_W-1:0] rem_reg  [0:Q_W-1];
    logic [Q_W-1:0]   q_reg    [0:Q_W-1];
    logic [D_W-1:0]   d_reg    [0:Q_W-1];
    logic             neg_reg  [0:Q_W-1];
    logic             tiny_reg [0:Q_W-1];

    logic [K_W-1:0]   k_reg;
    logic             kneg_reg, ktiny_reg;
    logic signed [T_W-1:0] t_full;
    logic signed [TEMP_W-1:0] temp_next, temp_reg;

    // Restoring division of 2^64 by d, one quotient bit per stage.
    for (genvar j = 0; j < Q_W; j++)
    begin : g_div
        logic [REM_W-1:0] rin;
        logic [Q_W-1:0]   qin;
        logic [D_W-1:0]   din;
        logic             nin, tin;
        logic [REM_W:0]   two_r;
        logic             ge;

        if (j == 0)
        begin : g_first
            assign rin = REM_INIT;
            assign qin = '0;
            assign din = d;
            assign nin = neg;
            assign tin = tiny;
        end
        else
        begin : g_next
            assign rin = rem_reg[j-1];
            assign qin = q_reg[j-1];
            assign din = d_reg[j-1];
            assign nin = neg_reg[j-1];
            assign tin = tiny_reg[j-1];
        end

        assign two_r = {rin, 1'b0};
        assign ge    = two_r >= (REM_W+1)'(din);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= ge ? REM_W'(two_r - (REM_W+1)'(din)) : REM_W'(two_r);
                q_reg[j]    <= {qin[Q_W-2:0], ge};
                d_reg[j]    <= din;
                neg_reg[j]  <= nin;
                tiny_reg[j] <= tin;
            end
        end
    end

    // Kelvin in Q8 with the signed offset, then saturation.
    always_comb
    begin
        t_full = (kneg_reg ? -$signed({2'b0, k_reg}) : $signed({2'b0, k_reg}))
               - T_W'(KELVIN_Q8);
        if (ktiny_reg)
        begin
            temp_next = kneg_reg ? TEMP_W'(TEMP_MIN) : TEMP_W'(TEMP_MAX);
        end
        else if (t_full > T_W'(TEMP_MAX))
        begin
            temp_next = TEMP_W'(TEMP_MAX);
        end
        else if (t_full < T_W'(TEMP_MIN))
        begin
            temp_next = TEMP_W'(TEMP_MIN);
        end
        else
        begin
            temp_next = TEMP_W'(t_full);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Round half up: add one when twice the remainder reaches d.
            k_reg     <= K_W'(q_reg[Q_W-1])
                       + K_W'({rem_reg[Q_W-1], 1'b0} >= (REM_W+1)'(d_reg[Q_W-1]));
            kneg_reg  <= neg_reg[Q_W-1];
            ktiny_reg <= tiny_reg[Q_W-1];
            temp_reg  <= temp_next;
        end
    end

    assign temp = temp_reg;

endmodule
`default_nettype wire

FILE: rtl/thermistor_adc_to_celsius_unit.sv
// Throughput: one code per cycle; every stage holds while a result waits on m_tready.
// The depth is set by the 28 squaring stages of the log units, four rounded multiplies
// and a 19-stage restoring divider for the reciprocal.
// Reset clears the valid bits and loads the default coefficients and divider value.
`default_nettype none
`include "thermistor_adc_to_celsius_unit_macros.svh"
module thermistor_adc_to_celsius_unit #(
    parameter int unsigned ADC_FULL_SCALE = tacu_pkg::ADC_FULL_SCALE_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tacu_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [tacu_pkg::PDATA_W-1:0]  pwdata,
    output logic      [tacu_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [15:0]                   s_tdata,  // [11:0] adc_code
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [23:0]                        m_tdata,  // [16:0] temp_celsius
    output logic                               m_tuser   // [0] in_range
);
    import tacu_pkg::*;

    localparam int LAT = 1 + LOG_LAT + 1 + 4 * MUL_LAT + 2 + DIV_LAT + 1;
    localparam logic [LX_W-1:0] FULL = LX_W'(ADC_FULL_SCALE);

    // Configuration registers.
    logic signed [COEF_W-1:0] coef_a_reg, coef_b_reg, coef_c_reg;
    logic [DIV_W-1:0]         divider_reg;
    tacu_reg_t                reg_sel;
    logic                     wr_en;

    assign pready  = 1'b1;
    assign reg_sel = tacu_reg_t'(paddr[REG_LSB +: 2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg  <= COEF_A_RST;
            coef_b_reg  <= COEF_B_RST;
            coef_c_reg  <= COEF_C_RST;
            divider_reg <= DIVIDER_RST;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_COEF_A:  coef_a_reg  <= pwdata[COEF_W-1:0];
                REG_COEF_B:  coef_b_reg  <= pwdata[COEF_W-1:0];
                REG_COEF_C:  coef_c_reg  <= pwdata[COEF_W-1:0];
                REG_DIVIDER: divider_reg <= pwdata[DIV_W-1:0];
                default:     ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (reg_sel)
            REG_COEF_A:  prdata = PDATA_W'(coef_a_reg);
            REG_COEF_B:  prdata = PDATA_W'(coef_b_reg);
            REG_COEF_C:  prdata = PDATA_W'(coef_c_reg);
            REG_DIVIDER: prdata = PDATA_W'(divider_reg);
            default:     prdata = '0;
        endcase
    end

    // Pipeline advance: every stage moves unless a result is held.
    tacu_ctl_t ctl_reg [0:LAT-1];
    tacu_ctl_t ctl_next;
    logic      pipe_en;
    logic [CODE_W-1:0] code;

    assign pipe_en  = !ctl_reg[LAT-1].valid || m_tready;
    assign s_tready = pipe_en;
    assign code     = s_tdata[CODE_W-1:0];

    always_comb
    begin
        ctl_next.valid    = s_tvalid;
        ctl_next.in_range = (code != '0) && (LX_W'(code) < FULL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                ctl_reg[i] <= '0;
            end
        end
        else if (pipe_en)
        begin
            ctl_reg[0] <= ctl_next;
            for (int i = 1; i < LAT; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    // Input stage: the three log arguments.
    logic [LX_W-1:0] xdiv_reg, xcode_reg, xrest_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            xdiv_reg  <= (divider_reg == '0) ? LX_W'(1) : LX_W'(divider_reg);
            xcode_reg <= LX_W'(code);
            xrest_reg <= FULL - LX_W'(code);
        end
    end

    // Logs of the divider, the code and the remaining span.
    logic [LG_W-1:0] lg_div, lg_code, lg_rest;

    tacu_log2 u_log_div  (.clk(clk), .en(pipe_en), .x(xdiv_reg),  .lg(lg_div));
    tacu_log2 u_log_code (.clk(clk), .en(pipe_en), .x(xcode_reg), .lg(lg_code));
    tacu_log2 u_log_rest (.clk(clk), .en(pipe_en), .x(xrest_reg), .lg(lg_rest));

    // log2 of the thermistor resistance.
    logic signed [G_W-1:0] g_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            g_reg <= $signed(G_W'(lg_div) + G_W'(lg_code) - G_W'(lg_rest));
        end
    end

    // Natural log and its powers.
    logic signed [L_W-1:0]  l_val;
    logic signed [L2_W-1:0] l2_val;
    logic signed [L3_W-1:0] l3_val;
    logic signed [TB_W-1:0] tb_val;
    logic signed [TC_W-1:0] tc_val;
    logic signed [L_W-1:0]  l_dly_reg [0:2*MUL_LAT-1];

    tacu_mulsh #(.WA(G_W), .WB(LN2_W), .SH(30), .WO(L_W)) u_mul_ln (
        .clk(clk), .en(pipe_en), .a(g_reg), .b($signed(LN2_Q30)), .p(l_val)
    );

    // L held to line up with the later products.
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            l_dly_reg[0] <= l_val;
            for (int i = 1; i < 2 * MUL_LAT; i++)
            begin
                l_dly_reg[i] <= l_dly_reg[i-1];
            end
        end
    end

    tacu_mulsh #(.WA(L_W), .WB(L_W), .SH(LG_FRAC), .WO(L2_W)) u_mul_l2 (
        .clk(clk), .en(pipe_en), .a(l_val), .b(l_val), .p(l2_val)
    );

    tacu_mulsh #(.WA(L2_W), .WB(L_W), .SH(LG_FRAC), .WO(L3_W)) u_mul_l3 (
        .clk(clk), .en(pipe_en), .a(l2_val), .b(l_dly_reg[MUL_LAT-1]), .p(l3_val)
    );

    tacu_mulsh #(.WA(COEF_W), .WB(L3_W), .SH(LG_FRAC), .WO(TC_W)) u_mul_tc (
        .clk(clk), .en(pipe_en), .a(coef_c_reg), .b(l3_val), .p(tc_val)
    );

    tacu_mulsh #(.WA(COEF_W), .WB(L_W), .SH(LG_FRAC), .WO(TB_W)) u_mul_tb (
        .clk(clk), .en(pipe_en), .a(coef_b_reg), .b(l_dly_reg[2*MUL_LAT-1]), .p(tb_val)
    );

    // Steinhart-Hart sum and its magnitude.
    logic signed [S_W-1:0] s_reg;
    logic [S_W-1:0]        s_abs;
    logic [D_W-1:0]        d_reg;
    logic                  neg_reg, tiny_reg;

    assign s_abs = s_reg[S_W-1] ? S_W'(-s_reg) : S_W'(s_reg);

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s_reg    <= S_W'(coef_a_reg) + S_W'(tb_val) + S_W'(tc_val);
            d_reg    <= D_W'(s_abs);
            neg_reg  <= s_reg[S_W-1];
            tiny_reg <= s_abs < (S_W'(1) << TINY_EXP);
        end
    end

    // Reciprocal, offset to Celsius and saturation.
    logic signed [TEMP_W-1:0] temp_val;

    tacu_recip u_recip (
        .clk(clk), .en(pipe_en), .d(d_reg), .neg(neg_reg), .tiny(tiny_reg), .temp(temp_val)
    );

    // Output register; codes out of range give zero.
    logic signed [TEMP_W-1:0] temp_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            temp_reg <= ctl_reg[LAT-2].in_range ? temp_val : '0;
        end
    end

    assign m_tvalid = ctl_reg[LAT-1].valid;
    assign m_tuser  = ctl_reg[LAT-1].in_range;
    assign m_tdata  = {{(24 - TEMP_W){1'b0}}, temp_reg};

    // Checks.
    `TACU_ASSERT(a_out_of_range_zero, m_tvalid && !m_tuser |-> m_tdata == '0, "out-of-range code gave a nonzero temperature")
    `TACU_ASSERT(a_stall_holds_entry, !pipe_en |=> $stable(ctl_reg[0]), "entry stage moved during a stall")
    `TACU_ASSERT(a_transfer_enters, s_tvalid && s_tready |=> ctl_reg[0].valid, "accepted transfer did not enter the pipeline")
    `TACU_ASSERT_NEVER(a_ready_while_held, m_tvalid && !m_tready && s_tready, "input ready while the result is held")

endmodule
`default_nettype wire
